/* sv/kbhm_pkg.sv */
// ----------------------------------------------------------------------------
// kbhm_pkg
// Shared constants for the key to button hold mapper: widths, key codes,
// button and action bit positions, escape parser phases and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package kbhm_pkg;

  localparam int TIME_BITS = 40;
  localparam int NOW_IN_W  = 40;
  localparam int NOW_W     = (TIME_BITS < NOW_IN_W) ? TIME_BITS : NOW_IN_W;
  localparam int DL_W      = TIME_BITS + 1;
  localparam int HOLD_W    = 16;
  localparam int NUM_BTN   = 8;
  localparam int NUM_ACT   = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_HOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTION_HOLD = 1'd1;

  localparam logic OP_KEY   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [HOLD_W-1:0] BUTTON_HOLD_RST = 16'd220;
  localparam logic [HOLD_W-1:0] ACTION_HOLD_RST = 16'd250;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_CSI  = 2'd2;

  localparam int BTN_UP     = 0;
  localparam int BTN_DOWN   = 1;
  localparam int BTN_LEFT   = 2;
  localparam int BTN_RIGHT  = 3;
  localparam int BTN_A      = 4;
  localparam int BTN_B      = 5;
  localparam int BTN_START  = 6;
  localparam int BTN_SELECT = 7;

  localparam int ACT_LOAD  = 0;
  localparam int ACT_SAVE  = 1;
  localparam int ACT_CLEAR = 2;

  localparam logic [7:0] KEY_ESC      = 8'h1B;
  localparam logic [7:0] KEY_LBRACKET = 8'h5B;
  localparam logic [7:0] KEY_UC_O     = 8'h4F;
  localparam logic [7:0] KEY_UC_A     = 8'h41;
  localparam logic [7:0] KEY_UC_B     = 8'h42;
  localparam logic [7:0] KEY_UC_C     = 8'h43;
  localparam logic [7:0] KEY_UC_D     = 8'h44;
  localparam logic [7:0] KEY_UC_Z     = 8'h5A;
  localparam logic [7:0] CASE_BIT     = 8'h20;
  localparam logic [7:0] KEY_W        = 8'h77;
  localparam logic [7:0] KEY_S        = 8'h73;
  localparam logic [7:0] KEY_A        = 8'h61;
  localparam logic [7:0] KEY_D        = 8'h64;
  localparam logic [7:0] KEY_J        = 8'h6A;
  localparam logic [7:0] KEY_X        = 8'h78;
  localparam logic [7:0] KEY_K        = 8'h6B;
  localparam logic [7:0] KEY_Z        = 8'h7A;
  localparam logic [7:0] KEY_CR       = 8'h0D;
  localparam logic [7:0] KEY_LF       = 8'h0A;
  localparam logic [7:0] KEY_SPACE    = 8'h20;
  localparam logic [7:0] KEY_TAB      = 8'h09;
  localparam logic [7:0] KEY_R        = 8'h72;
  localparam logic [7:0] KEY_P        = 8'h70;
  localparam logic [7:0] KEY_C        = 8'h63;

endpackage

`default_nettype wire

/* sv/key_to_button_hold_mapper.sv */
// ----------------------------------------------------------------------------
// key_to_button_hold_mapper
// Parses key bytes into pad button and action presses with hold deadlines
// and answers state queries with the buttons and actions still held.
// ----------------------------------------------------------------------------
// Query path: an accepted request goes to the input register, its result to the result register.
// Throughput: one request per cycle; the input register drains whenever the
//   result register is free or being taken, key bytes never wait on output.
// Reset: parser phase idle, all deadlines 0, hold times 220 ms and 250 ms.
// ----------------------------------------------------------------------------
`default_nettype none

module key_to_button_hold_mapper (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [47:0]                    s_axis_tdata,  // key_byte[7:0], now_ms[47:8]
  input  wire logic [0:0]                     s_axis_tuser,  // op[0]
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [15:0]                         m_axis_tdata,  // buttons[7:0], actions[10:8]
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [kbhm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [kbhm_pkg::HOLD_W-1:0]    cfg_data_i
);
  import kbhm_pkg::*;

  logic [HOLD_W-1:0]  button_hold_q, action_hold_q;
  logic [1:0]         phase_q, phase_d;
  logic [DL_W-1:0]    btn_dl_q [NUM_BTN];
  logic [DL_W-1:0]    act_dl_q [NUM_ACT];

  logic               in_vld_q;
  logic               in_op_q;
  logic [7:0]         in_key_q;
  logic [NOW_W-1:0]   in_now_q;

  logic               out_vld_q;
  logic [NUM_BTN-1:0] out_btn_q, held_btn;
  logic [NUM_ACT-1:0] out_act_q, held_act;

  logic               adv, in_take;
  logic [7:0]         folded;
  logic [NUM_BTN-1:0] btn_hit;
  logic [NUM_ACT-1:0] act_hit;
  logic [DL_W-1:0]    now_ext, btn_dl_new, act_dl_new;

  assign adv           = in_vld_q && (in_op_q == OP_KEY || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, out_act_q, out_btn_q};

  assign now_ext    = DL_W'(in_now_q);
  assign btn_dl_new = now_ext + DL_W'(button_hold_q);
  assign act_dl_new = now_ext + DL_W'(action_hold_q);

  always_comb begin
    folded = in_key_q;
    if (in_key_q >= KEY_UC_A && in_key_q <= KEY_UC_Z) begin
      folded = in_key_q | CASE_BIT;
    end
  end

  always_comb begin
    phase_d = PH_IDLE;
    btn_hit = '0;
    act_hit = '0;
    unique case (phase_q)
      PH_ESC: begin
        phase_d = (in_key_q == KEY_LBRACKET || in_key_q == KEY_UC_O) ? PH_CSI : PH_IDLE;
      end
      PH_CSI: begin
        unique case (in_key_q)
          KEY_UC_A: btn_hit[BTN_UP]    = 1'b1;
          KEY_UC_B: btn_hit[BTN_DOWN]  = 1'b1;
          KEY_UC_C: btn_hit[BTN_RIGHT] = 1'b1;
          KEY_UC_D: btn_hit[BTN_LEFT]  = 1'b1;
          default: ;
        endcase
      end
      default: begin
        if (in_key_q == KEY_ESC) begin
          phase_d = PH_ESC;
        end else begin
          unique case (folded)
            KEY_W:              btn_hit[BTN_UP]     = 1'b1;
            KEY_S:              btn_hit[BTN_DOWN]   = 1'b1;
            KEY_A:              btn_hit[BTN_LEFT]   = 1'b1;
            KEY_D:              btn_hit[BTN_RIGHT]  = 1'b1;
            KEY_J, KEY_X:       btn_hit[BTN_A]      = 1'b1;
            KEY_K, KEY_Z:       btn_hit[BTN_B]      = 1'b1;
            KEY_CR, KEY_LF:     btn_hit[BTN_START]  = 1'b1;
            KEY_SPACE, KEY_TAB: btn_hit[BTN_SELECT] = 1'b1;
            KEY_R:              act_hit[ACT_LOAD]   = 1'b1;
            KEY_P:              act_hit[ACT_SAVE]   = 1'b1;
            KEY_C:              act_hit[ACT_CLEAR]  = 1'b1;
            default: ;
          endcase
        end
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < NUM_BTN; i++) begin
      held_btn[i] = btn_dl_q[i] > now_ext;
    end
    for (int i = 0; i < NUM_ACT; i++) begin
      held_act[i] = act_dl_q[i] > now_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      button_hold_q <= BUTTON_HOLD_RST;
      action_hold_q <= ACTION_HOLD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_BUTTON_HOLD: button_hold_q <= cfg_data_i;
        REG_ACTION_HOLD: action_hold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      for (int i = 0; i < NUM_BTN; i++) begin
        btn_dl_q[i] <= '0;
      end
      for (int i = 0; i < NUM_ACT; i++) begin
        act_dl_q[i] <= '0;
      end
    end else if (adv && in_op_q == OP_KEY) begin
      phase_q <= phase_d;
      for (int i = 0; i < NUM_BTN; i++) begin
        if (btn_hit[i]) begin
          btn_dl_q[i] <= btn_dl_new;
        end
      end
      for (int i = 0; i < NUM_ACT; i++) begin
        if (act_hit[i]) begin
          act_dl_q[i] <= act_dl_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv && in_op_q == OP_QUERY) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q  <= s_axis_tuser[0];
      in_key_q <= s_axis_tdata[7:0];
      in_now_q <= s_axis_tdata[8 +: NOW_W];
    end
    if (adv && in_op_q == OP_QUERY) begin
      out_btn_q <= held_btn;
      out_act_q <= held_act;
    end
  end

endmodule

`default_nettype wire
